>>> design/mtxws_pkg.sv
`timescale 1ns / 1ps

package mtxws_pkg;

    // table sizes
    localparam int MUTEX_COUNT   = 32;
    localparam int PROCESS_COUNT = 16;
    localparam int STACK_DEPTH   = PROCESS_COUNT - 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 5;
    localparam int PID_W    = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(PROCESS_COUNT);
    localparam int IDX_W    = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
    localparam int ADDR_W   = IDX_W + CNT_W;
    localparam int RAM_DEPTH = MUTEX_COUNT * (2 ** CNT_W);

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [PID_W-1:0] pid;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     new_id;
        logic                granted;
        logic                must_wait;
        logic                wake_valid;
    } res_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [PID_W-1:0]  wr_data;
    } ram_ctl_t;

endpackage

>>> design/mutex_table_with_waiter_stack_unit.sv
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// request  | in_valid, in_stall | op, mutex_id, caller_pid
// result   | out_valid,out_stall| status, new_id, granted, must_wait,
//          |                    | wake_valid, wake_pid
//
// one request per cycle while in_stall is low; a taken beat passes the input
// register, then the table update and the result register with the stack read,
// before its result is on the outputs
// reset clears allocation, lock and waiter count flags; the waiter stack
// memory is not cleared, as only pushed entries are ever popped
// a held result stalls the request register, which then raises in_stall

module mutex_table_with_waiter_stack_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mtxws_pkg::OP_W-1:0]          op,
    input  logic [mtxws_pkg::ID_W-1:0]          mutex_id,
    input  logic [mtxws_pkg::PID_W-1:0]         caller_pid,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mtxws_pkg::STATUS_W-1:0]      status,
    output logic [mtxws_pkg::ID_W-1:0]          new_id,
    output logic                                granted,
    output logic                                must_wait,
    output logic                                wake_valid,
    output logic [mtxws_pkg::PID_W-1:0]         wake_pid
);

    logic                   req_valid_reg;
    mtxws_pkg::req_t        req_reg;
    logic                   res_valid_reg;
    mtxws_pkg::res_t        res_reg;
    mtxws_pkg::res_t        res_next;
    mtxws_pkg::ram_ctl_t    ram_ctl;
    logic [mtxws_pkg::PID_W-1:0] ram_rd;
    logic                   advance;
    logic                   fire;
    logic                   in_take;

    // flow control
    assign advance  = !res_valid_reg || !out_stall;
    assign fire     = req_valid_reg && advance;
    assign in_stall = req_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.op  <= op;
            req_reg.id  <= mutex_id;
            req_reg.pid <= caller_pid;
        end
    end

    mtxws_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req_reg),
        .res   (res_next),
        .ram   (ram_ctl)
    );

    mtxws_stack_ram u_stack_ram
    (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_data (ram_rd)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign status     = res_reg.status;
    assign new_id     = res_reg.new_id;
    assign granted    = res_reg.granted;
    assign must_wait  = res_reg.must_wait;
    assign wake_valid = res_reg.wake_valid;
    assign wake_pid   = res_reg.wake_valid ? ram_rd : '0;

    // checks
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({granted, must_wait, wake_valid}))
        else $error("more than one outcome flag on a result");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != mtxws_pkg::ST_OK) |->
        (!granted && !must_wait && !wake_valid && new_id == '0))
        else $error("error result carries outcome fields");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (req_valid_reg && res_valid_reg && out_stall))
        else $error("request stalled without a held result");

    a_res_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (fire) |=> res_valid_reg)
        else $error("processed request produced no result");

endmodule

>>> design/mtxws_free_enc.sv
`timescale 1ns / 1ps

module mtxws_free_enc
(
    input  logic [mtxws_pkg::MUTEX_COUNT-1:0] alloc,
    output logic                              found,
    output logic [mtxws_pkg::IDX_W-1:0]       idx
);

    // lowest clear bit wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = mtxws_pkg::MUTEX_COUNT - 1; i >= 0; i--)
        begin
            if (!alloc[i])
            begin
                found = 1'b1;
                idx   = mtxws_pkg::IDX_W'(i);
            end
        end
    end

endmodule

>>> design/mtxws_stack_ram.sv
`timescale 1ns / 1ps

module mtxws_stack_ram
(
    input  logic                           clk,
    input  mtxws_pkg::ram_ctl_t            ctl,
    output logic [mtxws_pkg::PID_W-1:0]    rd_data
);

    logic [mtxws_pkg::PID_W-1:0] mem [mtxws_pkg::RAM_DEPTH];
    logic [mtxws_pkg::PID_W-1:0] rd_data_reg;

    // one port, write on push, registered read on pop
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mtxws_table.sv
`timescale 1ns / 1ps

module mtxws_table
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  mtxws_pkg::req_t       req,
    output mtxws_pkg::res_t       res,
    output mtxws_pkg::ram_ctl_t   ram
);

    localparam int MC = mtxws_pkg::MUTEX_COUNT;

    logic [MC-1:0]                  alloc_reg;
    logic [MC-1:0]                  alloc_next;
    logic [MC-1:0]                  lock_reg;
    logic [MC-1:0]                  lock_next;
    logic [mtxws_pkg::CNT_W-1:0]    cnt_reg  [MC];
    logic [mtxws_pkg::CNT_W-1:0]    cnt_next [MC];

    logic                           free_found;
    logic [mtxws_pkg::IDX_W-1:0]    free_idx;
    logic [mtxws_pkg::IDX_W-1:0]    idx;
    logic                           id_ok;
    logic [mtxws_pkg::CNT_W-1:0]    cur_cnt;

    mtxws_free_enc u_free_enc
    (
        .alloc (alloc_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    assign idx     = mtxws_pkg::IDX_W'(req.id);
    assign id_ok   = (int'(req.id) < MC) && alloc_reg[idx];
    assign cur_cnt = cnt_reg[idx];

    // decode one request against the table
    always_comb
    begin
        alloc_next  = alloc_reg;
        lock_next   = lock_reg;
        cnt_next    = cnt_reg;
        res         = '0;
        ram.wr_en   = 1'b0;
        ram.rd_en   = 1'b0;
        ram.addr    = {idx, cur_cnt};
        ram.wr_data = req.pid;

        if (req.op == mtxws_pkg::OP_CREATE)
        begin
            if (free_found)
            begin
                alloc_next[free_idx] = 1'b1;
                lock_next[free_idx]  = 1'b0;
                cnt_next[free_idx]   = '0;
                res.new_id           = mtxws_pkg::ID_W'(free_idx);
            end
            else
            begin
                res.status = mtxws_pkg::ST_NO_FREE;
            end
        end
        else if (!id_ok)
        begin
            res.status = mtxws_pkg::ST_NOT_ALLOC;
        end
        else
        begin
            unique case (req.op)
                mtxws_pkg::OP_FREE:
                begin
                    alloc_next[idx] = 1'b0;
                end
                mtxws_pkg::OP_ACQUIRE:
                begin
                    if (!lock_reg[idx])
                    begin
                        lock_next[idx] = 1'b1;
                        res.granted    = 1'b1;
                    end
                    else if (int'(cur_cnt) >= mtxws_pkg::STACK_DEPTH)
                    begin
                        res.status = mtxws_pkg::ST_STACK_FULL;
                    end
                    else
                    begin
                        // push caller onto the waiter stack
                        ram.wr_en      = 1'b1;
                        cnt_next[idx]  = cur_cnt + 1'b1;
                        res.must_wait  = 1'b1;
                    end
                end
                default:
                begin
                    // release: pop newest waiter and hand it the lock, or unlock if none wait
                    if (cur_cnt != '0)
                    begin
                        ram.rd_en      = 1'b1;
                        ram.addr       = {idx, cur_cnt - 1'b1};
                        cnt_next[idx]  = cur_cnt - 1'b1;
                        lock_next[idx] = 1'b1;
                        res.wake_valid = 1'b1;
                    end
                    else
                    begin
                        lock_next[idx] = 1'b0;
                    end
                end
            endcase
        end

        if (!fire)
        begin
            ram.wr_en = 1'b0;
            ram.rd_en = 1'b0;
        end
    end

    // table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
            lock_reg  <= '0;
            for (int i = 0; i < MC; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            alloc_reg <= alloc_next;
            lock_reg  <= lock_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
